// ===== src/dspd_pkg.sv =====
// Shared constants and types for the dual side PID drive unit.
`timescale 1ns / 1ps

package dspd_pkg;

	localparam int FRAC_BITS_DEF   = 8;
	localparam int TOTAL_WIDTH_DEF = 48;

	localparam int PADDR_W = 4;
	localparam int MAXV_W  = 15;
	localparam logic [MAXV_W-1:0] MAXV_RESET = 15'd25600;

	localparam logic [1:0] REG_LEFT_TARGET  = 2'd0;
	localparam logic [1:0] REG_RIGHT_TARGET = 2'd1;
	localparam logic [1:0] REG_MAX_VELOCITY = 2'd2;

	// floor(x / 3) = (x * RECIP3) >> 33 and floor(x / 5) = (x * RECIP5) >> 34 for x < 2^32
	localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;
	localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;

	localparam int ACC_W = 18;

	typedef struct packed {
		logic mv1;
		logic mv2;
		logic mv3;
		logic mv4;
		logic mv5;
	} dspd_adv_t;

endpackage

// ===== src/dspd_if.sv =====
// Valid/ready channel interfaces for sample sets and drive commands.
`timescale 1ns / 1ps

interface dspd_in_if;
	logic               valid;
	logic               ready;
	logic               restart;
	logic signed [31:0] left_front_pos;
	logic signed [31:0] left_back_pos;
	logic signed [31:0] right_front_pos;
	logic signed [31:0] right_back_pos;

	modport source (
		output valid, restart, left_front_pos, left_back_pos, right_front_pos, right_back_pos,
		input  ready
	);
	modport sink (
		input  valid, restart, left_front_pos, left_back_pos, right_front_pos, right_back_pos,
		output ready
	);
endinterface

interface dspd_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] left_drive;
	logic signed [15:0] right_drive;
	logic               done_res;

	modport source (
		output valid, left_drive, right_drive, done_res,
		input  ready
	);
	modport sink (
		input  valid, left_drive, right_drive, done_res,
		output ready
	);
endinterface

// ===== src/dspd_cfg.sv =====
// APB register file: left target, right target and velocity clamp.
`timescale 1ns / 1ps

module dspd_cfg
	import dspd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output logic signed [31:0]  left_target,
	output logic signed [31:0]  right_target,
	output logic [MAXV_W-1:0]   max_velocity
);

	logic       wr_en;
	logic [1:0] reg_idx;

	logic signed [31:0] left_target_q;
	logic signed [31:0] right_target_q;
	logic [MAXV_W-1:0]  max_velocity_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_target_q  <= '0;
			right_target_q <= '0;
			max_velocity_q <= MAXV_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_LEFT_TARGET:  left_target_q  <= pwdata;
				REG_RIGHT_TARGET: right_target_q <= pwdata;
				REG_MAX_VELOCITY: max_velocity_q <= pwdata[MAXV_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_LEFT_TARGET:  prdata = left_target_q;
			REG_RIGHT_TARGET: prdata = right_target_q;
			REG_MAX_VELOCITY: prdata = {{(32-MAXV_W){1'b0}}, max_velocity_q};
			default:          prdata = '0;
		endcase
	end

	assign left_target  = left_target_q;
	assign right_target = right_target_q;
	assign max_velocity = max_velocity_q;

endmodule

// ===== src/dspd_side.sv =====
// One side of the PID loop: error, saturating total, constant divides, clamp.
`timescale 1ns / 1ps

module dspd_side
	import dspd_pkg::*;
#(
	parameter int TOTAL_WIDTH = TOTAL_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dspd_adv_t          adv,
	input  logic               restart_s1,
	input  logic signed [31:0] front_s1,
	input  logic signed [31:0] back_s1,
	input  logic signed [31:0] target,
	input  logic [MAXV_W-1:0]  max_velocity,
	output logic signed [15:0] drive
);

	localparam int TW = TOTAL_WIDTH;
	localparam logic signed [TW-1:0] TOT_MAX = {1'b0, {(TW-1){1'b1}}};
	localparam logic signed [TW-1:0] TOT_MIN = {1'b1, {(TW-1){1'b0}}};
	localparam logic signed [32:0] ACC_HI = 33'sd131071;
	localparam logic signed [32:0] ACC_LO = -33'sd131072;

	// stage 1: average and error
	logic signed [32:0] pos_sum;
	logic signed [32:0] avg_adj;
	logic signed [31:0] avg;
	logic signed [32:0] err;

	logic signed [32:0] err_s2;
	logic               rst_s2;

	// stage 2: error total loop and magnitudes
	logic signed [TW-1:0] tot_q;
	logic signed [TW-1:0] tot_pre;
	logic signed [TW:0]   tot_sum;
	logic signed [TW-1:0] tot_next;
	logic [32:0]          err_mag;
	logic [TW-1:0]        tot_mag;
	logic [63:0]          tot_mag64;
	logic [31:0]          tot_cap;

	logic [31:0] em_s3;
	logic        eneg_s3;
	logic [31:0] tx_s3;
	logic        tneg_s3;
	logic        rst_s3;

	// stage 3: reciprocal multiplies
	logic [63:0] prod3;
	logic [63:0] prod5;

	logic [30:0] q6_s4;
	logic [29:0] q20_s4;
	logic        eneg_s4;
	logic        tneg_s4;
	logic        rst_s4;

	// stage 4: combine and saturate
	logic signed [32:0] p6;
	logic signed [32:0] p20;
	logic signed [32:0] acc_sum;
	logic signed [ACC_W-1:0] acc;

	logic signed [ACC_W-1:0] acc_s5;
	logic                    rst_s5;

	// stage 5: velocity loop
	logic signed [16:0] vc_q;
	logic signed [15:0] prev_q;
	logic signed [16:0] vc_use;
	logic signed [15:0] pv_use;
	logic signed [16:0] vc_adj;
	logic signed [16:0] vc_div;
	logic signed [18:0] raw;
	logic signed [18:0] vmax;
	logic signed [18:0] vmin;
	logic signed [18:0] vel;
	logic signed [16:0] vc_next;

	assign pos_sum = {front_s1[31], front_s1} + {back_s1[31], back_s1};
	assign avg_adj = pos_sum + {32'd0, pos_sum[32]};
	assign avg     = avg_adj[32:1];
	assign err     = {target[31], target} - {avg[31], avg};

	always_ff @(posedge clk) begin
		if (adv.mv1) begin
			err_s2 <= err;
			rst_s2 <= restart_s1;
		end
	end

	assign tot_pre  = rst_s2 ? '0 : tot_q;
	assign tot_sum  = {tot_pre[TW-1], tot_pre} + {{(TW-32){err_s2[32]}}, err_s2};
	assign tot_next = (tot_sum[TW] != tot_sum[TW-1]) ? (tot_sum[TW] ? TOT_MIN : TOT_MAX)
		: tot_sum[TW-1:0];

	assign err_mag   = err_s2[32] ? 33'(-err_s2) : err_s2;
	assign tot_mag   = tot_pre[TW-1] ? TW'(-tot_pre) : tot_pre;
	assign tot_mag64 = 64'(tot_mag);
	// hold large totals at a value that still saturates the sum
	assign tot_cap   = (|tot_mag64[63:34]) ? '1 : tot_mag64[33:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_q <= '0;
		end else if (adv.mv2) begin
			tot_q <= tot_next;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.mv2) begin
			em_s3   <= err_mag[32:1];
			eneg_s3 <= err_s2[32];
			tx_s3   <= tot_cap;
			tneg_s3 <= tot_pre[TW-1];
			rst_s3  <= rst_s2;
		end
	end

	assign prod3 = 64'(em_s3) * 64'(RECIP3);
	assign prod5 = 64'(tx_s3) * 64'(RECIP5);

	always_ff @(posedge clk) begin
		if (adv.mv3) begin
			q6_s4   <= prod3[63:33];
			q20_s4  <= prod5[63:34];
			eneg_s4 <= eneg_s3;
			tneg_s4 <= tneg_s3;
			rst_s4  <= rst_s3;
		end
	end

	assign p6      = eneg_s4 ? -{2'b00, q6_s4} : {2'b00, q6_s4};
	assign p20     = tneg_s4 ? -{3'b000, q20_s4} : {3'b000, q20_s4};
	assign acc_sum = p6 + p20;

	always_comb begin
		if (acc_sum > ACC_HI) begin
			acc = ACC_HI[ACC_W-1:0];
		end else if (acc_sum < ACC_LO) begin
			acc = ACC_LO[ACC_W-1:0];
		end else begin
			acc = acc_sum[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv.mv4) begin
			acc_s5 <= acc;
			rst_s5 <= rst_s4;
		end
	end

	assign vc_use = rst_s5 ? '0 : vc_q;
	assign pv_use = rst_s5 ? {1'b0, max_velocity} : prev_q;
	assign vc_adj = vc_use + (vc_use[16] ? 17'sd7 : 17'sd0);
	assign vc_div = vc_adj >>> 3;
	assign raw    = {acc_s5[ACC_W-1], acc_s5} - {{2{vc_div[16]}}, vc_div};
	assign vmax   = {4'b0000, max_velocity};
	assign vmin   = -vmax;

	always_comb begin
		if (raw > vmax) begin
			vel = vmax;
		end else if (raw < vmin) begin
			vel = vmin;
		end else begin
			vel = raw;
		end
	end

	assign drive   = vel[15:0];
	assign vc_next = {pv_use[15], pv_use} - {drive[15], drive};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q   <= '0;
			prev_q <= '0;
		end else if (adv.mv5) begin
			vc_q   <= vc_next;
			prev_q <= drive;
		end
	end

endmodule

// ===== src/dual_side_pid_drive_unit.sv =====
// Top level of the dual side PID drive unit: pipeline control, sides and result register.
//
//   channel   dir  handshake        payload
//   in_ch     in   valid / ready    restart, four encoder positions
//   out_ch    out  valid / ready    left_drive, right_drive, done_res
//   apb       in   psel / penable   left_target, right_target, max_velocity
//
// One set per cycle unless out_ch stalls; results pass stages 1 to 5 and the result register.
// The error total closes its loop in stage 2 and the velocity loop in stage 5.
// Stage 3 holds the two 32x32 reciprocal multipliers for the /6 and /20 terms.
// Reset clears the stage valid flags, loop state and registers; no clearing pass.
// Each stage holds only while the next is full and held, so bubbles fill under a stall.
`timescale 1ns / 1ps

module dual_side_pid_drive_unit
	import dspd_pkg::*;
#(
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int TOTAL_WIDTH = TOTAL_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	dspd_in_if.sink            in_ch,
	dspd_out_if.source         out_ch
);

	localparam logic signed [17:0] DONE_LIM = 18'(1 << FRAC_BITS);

	logic signed [31:0] left_target;
	logic signed [31:0] right_target;
	logic [MAXV_W-1:0]  max_velocity;

	logic v1_q, v2_q, v3_q, v4_q, v5_q, out_valid_q;
	logic en1, en2, en3, en4, en5, en_out;
	logic accept;
	dspd_adv_t adv;

	logic               restart_s1;
	logic signed [31:0] lf_s1;
	logic signed [31:0] lb_s1;
	logic signed [31:0] rf_s1;
	logic signed [31:0] rb_s1;

	logic signed [15:0] left_vel;
	logic signed [15:0] right_vel;
	logic signed [17:0] left_ext;
	logic signed [17:0] right_ext;
	logic               done_nxt;

	logic signed [15:0] left_drive_q;
	logic signed [15:0] right_drive_q;
	logic               done_q;

	dspd_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.left_target  (left_target),
		.right_target (right_target),
		.max_velocity (max_velocity)
	);

	assign en_out = !out_valid_q || out_ch.ready;
	assign en5    = !v5_q || en_out;
	assign en4    = !v4_q || en5;
	assign en3    = !v3_q || en4;
	assign en2    = !v2_q || en3;
	assign en1    = !v1_q || en2;

	assign adv.mv1 = v1_q && en2;
	assign adv.mv2 = v2_q && en3;
	assign adv.mv3 = v3_q && en4;
	assign adv.mv4 = v4_q && en5;
	assign adv.mv5 = v5_q && en_out;

	assign in_ch.ready = en1;
	assign accept      = in_ch.valid && en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			v3_q        <= 1'b0;
			v4_q        <= 1'b0;
			v5_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1)    v1_q        <= in_ch.valid;
			if (en2)    v2_q        <= v1_q;
			if (en3)    v3_q        <= v2_q;
			if (en4)    v4_q        <= v3_q;
			if (en5)    v5_q        <= v4_q;
			if (en_out) out_valid_q <= v5_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			restart_s1 <= in_ch.restart;
			lf_s1      <= in_ch.left_front_pos;
			lb_s1      <= in_ch.left_back_pos;
			rf_s1      <= in_ch.right_front_pos;
			rb_s1      <= in_ch.right_back_pos;
		end
	end

	dspd_side #(
		.TOTAL_WIDTH (TOTAL_WIDTH)
	) u_left (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.restart_s1   (restart_s1),
		.front_s1     (lf_s1),
		.back_s1      (lb_s1),
		.target       (left_target),
		.max_velocity (max_velocity),
		.drive        (left_vel)
	);

	dspd_side #(
		.TOTAL_WIDTH (TOTAL_WIDTH)
	) u_right (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.restart_s1   (restart_s1),
		.front_s1     (rf_s1),
		.back_s1      (rb_s1),
		.target       (right_target),
		.max_velocity (max_velocity),
		.drive        (right_vel)
	);

	assign left_ext  = {{2{left_vel[15]}}, left_vel};
	assign right_ext = {{2{right_vel[15]}}, right_vel};
	assign done_nxt  = (left_ext <= DONE_LIM) && (left_ext >= -DONE_LIM)
		&& (right_ext <= DONE_LIM) && (right_ext >= -DONE_LIM);

	always_ff @(posedge clk) begin
		if (adv.mv5) begin
			left_drive_q  <= left_vel;
			right_drive_q <= right_vel;
			done_q        <= done_nxt;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.left_drive  = left_drive_q;
	assign out_ch.right_drive = right_drive_q;
	assign out_ch.done_res    = done_q;

	// back-pressure reaches the input only through a blocked result
	a_ready_low_only_when_blocked: assert property (
		@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> (out_ch.valid && !out_ch.ready)
	) else $error("input held while the result register can drain");

	// a new result comes only from an item in the last stage
	a_result_from_stage5: assert property (
		@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(v5_q)
	) else $error("result valid without an item in the last stage");

	// an accepted transaction always lands in the input register
	a_accept_fills_s1: assert property (
		@(posedge clk) disable iff (!arst_n)
		accept |=> v1_q
	) else $error("accepted transaction lost at the input register");

endmodule
